// File: src/lbd_pkg.sv
`default_nettype none

package lbd_pkg;

   // on-time step per brightness level, range 1 to 256
   localparam int unsigned DIM_STEP = 1;
   localparam int unsigned STEP_W   = $clog2(DIM_STEP + 1);

   localparam int unsigned CNT_W  = 16;
   localparam int unsigned BAR_W  = 3;
   localparam int unsigned IND_W  = 8;
   localparam int unsigned PCT_W  = 8;
   localparam int unsigned LVL_W  = 8;
   localparam int unsigned IDX_W  = 3;
   localparam int unsigned CSR_W  = 16;

   // register indexes
   localparam logic [IDX_W-1:0] REG_BLINK_ENABLE = 3'd0;
   localparam logic [IDX_W-1:0] REG_GREEN_PERIOD = 3'd1;
   localparam logic [IDX_W-1:0] REG_RED_PERIOD   = 3'd2;
   localparam logic [IDX_W-1:0] REG_BLUE_PERIOD  = 3'd3;
   localparam logic [IDX_W-1:0] REG_DIM_ENABLE   = 3'd4;
   localparam logic [IDX_W-1:0] REG_DIM_LEVEL    = 3'd5;
   localparam logic [IDX_W-1:0] REG_DIM_PERIOD   = 3'd6;

   localparam logic [CNT_W-1:0] DIM_PERIOD_RESET = 16'd100;

   // battery thresholds in percent
   localparam logic [PCT_W-1:0] PCT_5SEG = 8'd90;
   localparam logic [PCT_W-1:0] PCT_4SEG = 8'd80;
   localparam logic [PCT_W-1:0] PCT_3SEG = 8'd70;
   localparam logic [PCT_W-1:0] PCT_2SEG = 8'd60;
   localparam logic [PCT_W-1:0] PCT_1SEG = 8'd50;

   typedef struct packed {
      logic             enable;
      logic [LVL_W-1:0] level;
      logic [CNT_W-1:0] period;
   } dim_cfg_type;

   function automatic logic [BAR_W-1:0] bar_from_charge(input logic [PCT_W-1:0] pct);
      logic [BAR_W-1:0] seg;
      if (pct >= PCT_5SEG)      seg = 3'd5;
      else if (pct >= PCT_4SEG) seg = 3'd4;
      else if (pct >= PCT_3SEG) seg = 3'd3;
      else if (pct >= PCT_2SEG) seg = 3'd2;
      else if (pct >= PCT_1SEG) seg = 3'd1;
      else                      seg = 3'd0;
      return seg;
   endfunction

endpackage

`default_nettype wire

// File: src/lbd_blink.sv
`default_nettype none

module lbd_blink
   import lbd_pkg::*;
(
   input  wire              clock,
   input  wire              reset,
   input  wire              advance,
   input  wire              enable,
   input  wire  [CNT_W-1:0] period,
   output logic             led_in
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_inc;
   logic             led_ff;

   // count the tick, restart and toggle once past the period
   always_comb begin
      count_inc = count_ff + 16'd1;
      count_in  = count_ff;
      led_in    = led_ff;
      if (enable) begin
         if (count_inc > period) begin
            count_in = '0;
            led_in   = ~led_ff;
         end else begin
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         led_ff   <= 1'b0;
      end else if (advance) begin
         count_ff <= count_in;
         led_ff   <= led_in;
      end
   end

endmodule

`default_nettype wire

// File: src/lbd_dim.sv
`default_nettype none

module lbd_dim
   import lbd_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               advance,
   input  dim_cfg_type       cfg,
   input  wire  [PCT_W-1:0]  charge_percent,
   input  wire  [IND_W-1:0]  indicator_value,
   output logic [BAR_W-1:0]  bar_in,
   output logic [IND_W-1:0]  indicator_in
);

   logic [CNT_W-1:0]       dim_count_ff;
   logic [CNT_W-1:0]       dim_count_in;
   logic [CNT_W-1:0]       count_inc;
   logic [BAR_W-1:0]       bar_hold_ff;
   logic [IND_W-1:0]       indicator_hold_ff;
   logic [BAR_W-1:0]       bar_direct;
   logic [STEP_W+LVL_W-1:0] duty_full;
   logic [CNT_W-1:0]       duty;

   assign bar_direct = bar_from_charge(charge_percent);
   assign duty_full  = (STEP_W+LVL_W)'(DIM_STEP) * (STEP_W+LVL_W)'(cfg.level);
   assign duty       = CNT_W'(duty_full);

   // when enabled: show while within duty, hold on restart, blank otherwise; show directly when disabled
   always_comb begin
      count_inc    = dim_count_ff + 16'd1;
      dim_count_in = dim_count_ff;
      bar_in       = bar_direct;
      indicator_in = indicator_value;
      if (cfg.enable) begin
         dim_count_in = count_inc;
         if (count_inc <= duty) begin
            bar_in       = bar_direct;
            indicator_in = indicator_value;
         end else if (count_inc >= cfg.period) begin
            dim_count_in = '0;
            bar_in       = bar_hold_ff;
            indicator_in = indicator_hold_ff;
         end else begin
            bar_in       = '0;
            indicator_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff      <= '0;
         bar_hold_ff       <= '0;
         indicator_hold_ff <= '0;
      end else if (advance) begin
         dim_count_ff      <= dim_count_in;
         bar_hold_ff       <= bar_in;
         indicator_hold_ff <= indicator_in;
      end
   end

endmodule

`default_nettype wire

// File: src/led_blink_and_dim_driver.sv
// LED blink and dim driver. Each request word is one timer tick (charge percent and
// indicator pattern) and gives exactly one response word with the three blink LED
// levels, the battery bar segment count and the indicator pattern after that tick.
// A tick is registered on entry and the whole update (blink counters, bar
// thresholds, PWM dimming compare) is done combinationally into the response
// register, so one word per cycle is sustained while rsp_tready stays high; the
// request side accepts while the input register is empty or its word moves on to
// a free or emptying response register. Registers are written through the csr port,
// which is always ready; write them only while no tick is in flight.
`default_nettype none

module led_blink_and_dim_driver
   import lbd_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   // request channel
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire  [15:0]       req_tdata,   // [7:0] charge_percent, [15:8] indicator_value
   // response channel
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [15:0]       rsp_tdata,   // [0] green_led, [1] red_led, [2] blue_led,
                                          // [5:3] bar_segments, [13:6] indicator_out,
                                          // [15:14] zero
   // register write channel
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire  [IDX_W-1:0]  csr_index,
   input  wire  [CSR_W-1:0]  csr_data
);

   // configuration
   logic [2:0]       blink_enable_ff;
   logic [CNT_W-1:0] green_period_ff;
   logic [CNT_W-1:0] red_period_ff;
   logic [CNT_W-1:0] blue_period_ff;
   dim_cfg_type      dim_cfg_ff;

   // pipeline
   logic             in_valid_ff;
   logic [PCT_W-1:0] pct_ff;
   logic [IND_W-1:0] ind_ff;
   logic             rsp_valid_ff;
   logic [15:0]      rsp_data_ff;
   logic             advance;
   logic             green_in;
   logic             red_in;
   logic             blue_in;
   logic [BAR_W-1:0] bar_in;
   logic [IND_W-1:0] indicator_in;

   assign csr_ready = 1'b1;

   // write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_enable_ff   <= '0;
         green_period_ff   <= '0;
         red_period_ff     <= '0;
         blue_period_ff    <= '0;
         dim_cfg_ff.enable <= 1'b0;
         dim_cfg_ff.level  <= '0;
         dim_cfg_ff.period <= DIM_PERIOD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_BLINK_ENABLE: blink_enable_ff   <= csr_data[2:0];
            REG_GREEN_PERIOD: green_period_ff   <= csr_data;
            REG_RED_PERIOD:   red_period_ff     <= csr_data;
            REG_BLUE_PERIOD:  blue_period_ff    <= csr_data;
            REG_DIM_ENABLE:   dim_cfg_ff.enable <= csr_data[0];
            REG_DIM_LEVEL:    dim_cfg_ff.level  <= csr_data[LVL_W-1:0];
            REG_DIM_PERIOD:   dim_cfg_ff.period <= csr_data;
            default: ;
         endcase
      end
   end

   // advance when the input stage holds a word and the response register frees up
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         pct_ff <= req_tdata[7:0];
         ind_ff <= req_tdata[15:8];
      end
   end

   lbd_blink u_green (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .enable  (blink_enable_ff[0]),
      .period  (green_period_ff),
      .led_in  (green_in)
   );

   lbd_blink u_red (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .enable  (blink_enable_ff[1]),
      .period  (red_period_ff),
      .led_in  (red_in)
   );

   lbd_blink u_blue (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .enable  (blink_enable_ff[2]),
      .period  (blue_period_ff),
      .led_in  (blue_in)
   );

   lbd_dim u_dim (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .cfg             (dim_cfg_ff),
      .charge_percent  (pct_ff),
      .indicator_value (ind_ff),
      .bar_in          (bar_in),
      .indicator_in    (indicator_in)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {2'b00, indicator_in, bar_in, blue_in, red_in, green_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
